>>> rtl/frtm_pkg.sv
// ----------------------------------------------------------------------------
// frtm_pkg
// Shared types, widths and codes for the frequency / rocof threshold monitor.
// ----------------------------------------------------------------------------
package frtm_pkg;

    // field widths
    localparam int RATE_W  = 16;
    localparam int COUNT_W = 16;
    localparam int FREQ_W  = 24;
    localparam int ROCL_W  = 31;
    localparam int ROC_W   = 32;
    localparam int CFG_W   = 31;
    localparam int ADDR_W  = 2;

    // bit-serial divider: quotient bits, remainder bits, step counter bits
    localparam int DIV_QW = 50;
    localparam int DIV_RW = 25;
    localparam int DIV_CW = $clog2(DIV_QW + 1);

    // bit-serial multiplier: multiplicand bits, multiplier bits, counter bits
    localparam int MUL_AW = 48;
    localparam int MUL_BW = 24;
    localparam int MUL_PW = MUL_AW + MUL_BW;
    localparam int MUL_CW = $clog2(MUL_BW + 1);

    // roc magnitude after dropping the eight fraction bits of the quotient
    localparam int MAG_W = DIV_QW - 8;

    // register indexes
    localparam logic [ADDR_W-1:0] CFG_SAMPLE_RATE = 2'd0;
    localparam logic [ADDR_W-1:0] CFG_FREQ_LIMIT  = 2'd1;
    localparam logic [ADDR_W-1:0] CFG_ROC_LIMIT   = 2'd2;

    // register reset values
    localparam logic [RATE_W-1:0] SAMPLE_RATE_RST = 16'd16000;
    localparam logic [FREQ_W-1:0] FREQ_LIMIT_RST  = 24'd12800;
    localparam logic [ROCL_W-1:0] ROC_LIMIT_RST   = 31'd2560;

    // sequencer states
    typedef enum logic [2:0] {
        ST_IDLE,
        ST_FDIV,
        ST_MUL1,
        ST_MUL2,
        ST_RDIV,
        ST_RES
    } state_t;

    // divider request
    typedef struct packed {
        logic              start;
        logic [DIV_RW-1:0] rem_init;
        logic [DIV_QW-1:0] dividend;
        logic [DIV_RW-1:0] divisor;
        logic [DIV_CW-1:0] steps;
    } div_req_t;

    // multiplier request
    typedef struct packed {
        logic              start;
        logic [MUL_AW-1:0] mcand;
        logic [MUL_BW-1:0] mplier;
    } mul_req_t;

endpackage

>>> rtl/frtm_sdiv.sv
// ----------------------------------------------------------------------------
// frtm_sdiv
// Restoring divider, one quotient bit per cycle, dividend shifted in msb first.
// ----------------------------------------------------------------------------
module frtm_sdiv (
    input  logic                       clk,
    input  logic                       rst_n,
    input  frtm_pkg::div_req_t         req,
    output logic                       done,
    output logic [frtm_pkg::DIV_QW-1:0] quot
);
    import frtm_pkg::*;

    logic [DIV_RW-1:0] rem_reg;
    logic [DIV_QW-1:0] dvd_reg;
    logic [DIV_RW-1:0] dsr_reg;
    logic [DIV_QW-1:0] quot_reg;
    logic [DIV_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [DIV_RW:0]   rem_shift;
    logic [DIV_RW:0]   rem_diff;
    logic              fits;
    logic [DIV_RW-1:0] rem_step;

    // one restoring step
    always_comb
    begin
        rem_shift = {rem_reg, dvd_reg[DIV_QW-1]};
        rem_diff  = rem_shift - {1'b0, dsr_reg};
        fits      = (rem_shift >= {1'b0, dsr_reg});
        rem_step  = fits ? rem_diff[DIV_RW-1:0] : rem_shift[DIV_RW-1:0];
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= req.steps;
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == DIV_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // remainder, dividend and quotient shift registers
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            rem_reg  <= req.rem_init;
            dvd_reg  <= req.dividend;
            dsr_reg  <= req.divisor;
            quot_reg <= '0;
        end
        else if (busy_reg)
        begin
            rem_reg  <= rem_step;
            dvd_reg  <= {dvd_reg[DIV_QW-2:0], 1'b0};
            quot_reg <= {quot_reg[DIV_QW-2:0], fits};
        end
    end

    assign done = done_reg;
    assign quot = quot_reg;

endmodule

>>> rtl/frtm_smul.sv
// ----------------------------------------------------------------------------
// frtm_smul
// Shift-add multiplier, one multiplier bit per cycle, lsb first.
// ----------------------------------------------------------------------------
module frtm_smul (
    input  logic                       clk,
    input  logic                       rst_n,
    input  frtm_pkg::mul_req_t         req,
    output logic                       done,
    output logic [frtm_pkg::MUL_PW-1:0] prod
);
    import frtm_pkg::*;

    logic [MUL_AW-1:0] hi_reg;
    logic [MUL_BW-1:0] lo_reg;
    logic [MUL_AW-1:0] mcand_reg;
    logic [MUL_CW-1:0] cnt_reg;
    logic              busy_reg;
    logic              done_reg;

    logic [MUL_AW:0]   sum;

    // partial product add
    always_comb
    begin
        sum = {1'b0, hi_reg} + {1'b0, (lo_reg[0] ? mcand_reg : '0)};
    end

    // step control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (req.start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= MUL_CW'(MUL_BW);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == MUL_CW'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // product shifts right, multiplier bits drop out the bottom
    always_ff @(posedge clk)
    begin
        if (req.start)
        begin
            hi_reg    <= '0;
            lo_reg    <= req.mplier;
            mcand_reg <= req.mcand;
        end
        else if (busy_reg)
        begin
            hi_reg <= sum[MUL_AW:1];
            lo_reg <= {sum[0], lo_reg[MUL_BW-1:1]};
        end
    end

    assign done = done_reg;
    assign prod = {hi_reg, lo_reg};

endmodule

>>> rtl/frequency_rocof_threshold_monitor_core.sv
// ----------------------------------------------------------------------------
// frequency_rocof_threshold_monitor_core
// Period count to frequency, rate of change of frequency and limit flags.
// ----------------------------------------------------------------------------
// Sequence: a zero count goes straight to the result; otherwise the bit-serial
// divider forms the frequency in 24 steps, and for later samples two 24-step
// shift-add multiplies and a 50-step divide form the rate of change.
// Flow: the next word is taken once the sequencer is idle, while the previous
// result may wait in the output reg.
// Reset: registers return to their defaults and the frequency history clears.
module frequency_rocof_threshold_monitor_core (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_wr_en,
    input  logic [frtm_pkg::ADDR_W-1:0]   cfg_addr,
    input  logic [frtm_pkg::CFG_W-1:0]    cfg_data,
    input  logic                          period_valid,
    output logic                          period_stall,
    input  logic [frtm_pkg::COUNT_W-1:0]  period_count,
    output logic                          result_valid,
    input  logic                          result_stall,
    output logic [frtm_pkg::FREQ_W-1:0]   freq_value,
    output logic signed [frtm_pkg::ROC_W-1:0] roc_value,
    output logic                          roc_valid,
    output logic                          limit_exceeded,
    output logic                          count_error
);
    import frtm_pkg::*;

    // configuration
    logic [RATE_W-1:0] sample_rate_reg;
    logic [FREQ_W-1:0] freq_limit_reg;
    logic [ROCL_W-1:0] roc_limit_reg;

    // history
    logic [FREQ_W-1:0] prev_freq_reg;
    logic              have_prev_reg;

    // per-word working registers
    state_t            state_reg;
    state_t            state_next;
    logic              err_reg;
    logic              valid_reg;
    logic              neg_reg;
    logic [FREQ_W-1:0] fn_reg;
    logic [FREQ_W-1:0] d_reg;
    logic [FREQ_W:0]   s_reg;
    logic [MAG_W-1:0]  mag_reg;

    // output register
    logic              out_valid_reg;
    logic [FREQ_W-1:0] out_freq_reg;
    logic [ROC_W-1:0]  out_roc_reg;
    logic              out_rvalid_reg;
    logic              out_exc_reg;
    logic              out_err_reg;

    // unit ports
    div_req_t          div_req;
    logic              div_done;
    logic [DIV_QW-1:0] div_quot;
    mul_req_t          mul_req;
    logic              mul_done;
    logic [MUL_PW-1:0] mul_prod;

    // sequencer strobes
    logic              accept;
    logic              cap_fn;
    logic              cap_mag;
    logic              load_out;

    // frequency from the divider, difference and sum against history
    logic [FREQ_W-1:0] fn_q;
    logic              fn_lt;
    logic [FREQ_W-1:0] d_calc;
    logic [FREQ_W:0]   s_calc;

    // result formatting
    logic              neg_eff;
    logic [ROC_W-1:0]  roc_bits;
    logic              exceeded;

    frtm_sdiv u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (div_req),
        .done  (div_done),
        .quot  (div_quot)
    );

    frtm_smul u_mul (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (mul_req),
        .done  (mul_done),
        .prod  (mul_prod)
    );

    // difference and sum of new and previous frequency
    always_comb
    begin
        fn_q   = div_quot[FREQ_W-1:0];
        fn_lt  = (fn_q < prev_freq_reg);
        d_calc = fn_lt ? (prev_freq_reg - fn_q) : (fn_q - prev_freq_reg);
        s_calc = {1'b0, fn_q} + {1'b0, prev_freq_reg};
    end

    // next state and unit requests
    always_comb
    begin
        state_next = state_reg;
        accept     = 1'b0;
        cap_fn     = 1'b0;
        cap_mag    = 1'b0;
        load_out   = 1'b0;
        div_req    = '0;
        mul_req    = '0;
        case (state_reg)
            ST_IDLE:
            begin
                if (period_valid)
                begin
                    accept = 1'b1;
                    if (period_count == '0)
                    begin
                        state_next = ST_RES;
                    end
                    else
                    begin
                        // sample_rate * 256 / count, 24 quotient bits
                        div_req.start    = 1'b1;
                        div_req.rem_init = '0;
                        div_req.dividend = {sample_rate_reg, 8'd0,
                                            (DIV_QW - RATE_W - 8)'(0)};
                        div_req.divisor  = DIV_RW'(period_count);
                        div_req.steps    = DIV_CW'(FREQ_W);
                        state_next       = ST_FDIV;
                    end
                end
            end
            ST_FDIV:
            begin
                if (div_done)
                begin
                    cap_fn = 1'b1;
                    if (have_prev_reg)
                    begin
                        // fn * fo
                        mul_req.start  = 1'b1;
                        mul_req.mcand  = MUL_AW'(prev_freq_reg);
                        mul_req.mplier = fn_q;
                        state_next     = ST_MUL1;
                    end
                    else
                    begin
                        state_next = ST_RES;
                    end
                end
            end
            ST_MUL1:
            begin
                if (mul_done)
                begin
                    // d * fn * fo
                    mul_req.start  = 1'b1;
                    mul_req.mcand  = mul_prod[MUL_AW-1:0];
                    mul_req.mplier = d_reg;
                    state_next     = ST_MUL2;
                end
            end
            ST_MUL2:
            begin
                if (mul_done)
                begin
                    // 2 * d * fn * fo / s; top bits preload the remainder
                    div_req.start    = 1'b1;
                    div_req.rem_init = DIV_RW'(mul_prod[MUL_PW-1:DIV_QW-1]);
                    div_req.dividend = {mul_prod[DIV_QW-2:0], 1'b0};
                    div_req.divisor  = s_reg;
                    div_req.steps    = DIV_CW'(DIV_QW);
                    state_next       = ST_RDIV;
                end
            end
            ST_RDIV:
            begin
                if (div_done)
                begin
                    cap_mag    = 1'b1;
                    state_next = ST_RES;
                end
            end
            ST_RES:
            begin
                if (!out_valid_reg || !result_stall)
                begin
                    load_out   = 1'b1;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // state register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // configuration writes
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sample_rate_reg <= SAMPLE_RATE_RST;
            freq_limit_reg  <= FREQ_LIMIT_RST;
            roc_limit_reg   <= ROC_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_addr)
                CFG_SAMPLE_RATE: sample_rate_reg <= cfg_data[RATE_W-1:0];
                CFG_FREQ_LIMIT:  freq_limit_reg  <= cfg_data[FREQ_W-1:0];
                CFG_ROC_LIMIT:   roc_limit_reg   <= cfg_data[ROCL_W-1:0];
                default:         ;
            endcase
        end
    end

    // frequency history, updated when a good word's result is issued
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prev_freq_reg <= '0;
            have_prev_reg <= 1'b0;
        end
        else if (load_out && !err_reg)
        begin
            prev_freq_reg <= fn_reg;
            have_prev_reg <= 1'b1;
        end
    end

    // per-word working registers
    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            err_reg   <= (period_count == '0);
            valid_reg <= 1'b0;
            neg_reg   <= 1'b0;
            mag_reg   <= '0;
        end
        if (cap_fn)
        begin
            fn_reg    <= fn_q;
            d_reg     <= d_calc;
            s_reg     <= s_calc;
            neg_reg   <= fn_lt;
            valid_reg <= have_prev_reg;
        end
        if (cap_mag)
        begin
            // a zero sum means both frequencies are zero
            mag_reg <= (s_reg == '0) ? '0 : div_quot[DIV_QW-1:8];
        end
    end

    // saturation and limit check
    always_comb
    begin
        neg_eff = neg_reg && (mag_reg != '0);
        if (neg_eff)
        begin
            if (mag_reg > MAG_W'(33'h1_0000_0000 >> 1))
            begin
                roc_bits = {1'b1, (ROC_W - 1)'(0)};
            end
            else
            begin
                roc_bits = ROC_W'(0) - mag_reg[ROC_W-1:0];
            end
        end
        else
        begin
            if (mag_reg > MAG_W'({1'b0, {(ROC_W - 1){1'b1}}}))
            begin
                roc_bits = {1'b0, {(ROC_W - 1){1'b1}}};
            end
            else
            begin
                roc_bits = mag_reg[ROC_W-1:0];
            end
        end
        exceeded = (fn_reg > freq_limit_reg) || (mag_reg > MAG_W'(roc_limit_reg));
    end

    // output valid
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!result_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    // output word
    always_ff @(posedge clk)
    begin
        if (load_out)
        begin
            out_err_reg    <= err_reg;
            out_freq_reg   <= err_reg ? '0 : fn_reg;
            out_roc_reg    <= err_reg ? '0 : roc_bits;
            out_rvalid_reg <= err_reg ? 1'b0 : valid_reg;
            out_exc_reg    <= err_reg ? 1'b0 : exceeded;
        end
    end

    assign period_stall   = (state_reg != ST_IDLE);
    assign result_valid   = out_valid_reg;
    assign freq_value     = out_freq_reg;
    assign roc_value      = out_roc_reg;
    assign roc_valid      = out_rvalid_reg;
    assign limit_exceeded = out_exc_reg;
    assign count_error    = out_err_reg;

endmodule
